### rtl/core/text_console_character_writer_top_assert.svh
// assertion macros shared by the console checker
`ifndef TEXT_CONSOLE_CHARACTER_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_CHARACTER_WRITER_TOP_ASSERT_SVH

// same-cycle implication, reset masks the check
`define TCW_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masks the check
`define TCW_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tcw_pkg.sv
// shared types and constants of the text console writer
package tcw_pkg;

  // field widths
  localparam int MODE_W      = 2;
  localparam int CHAR_W      = 8;
  localparam int IDX_W       = 11;
  localparam int CELL_W      = 16;
  localparam int POS_W       = 11;
  localparam int ATTR_W      = 8;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - CELL_W - POS_W;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_ATTR = 1'b0;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  // item modes
  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // character codes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;
  localparam int TAB_STEP = 8;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic fill_en;
    logic fill_blank;
    logic copy_en;
    logic put_en;
    logic home_en;
    logic pos_en;
    logic out_load;
  } tcw_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [MODE_W-1:0] in_mode;
    logic              scroll;
    logic              copy_last;
    logic              swp_end;
    logic              out_free;
  } tcw_sts_t;

endpackage

### rtl/core/text_console_character_writer_top.sv
// top level of the text console character writer
//
//  port group   dir  role          tdata / tuser contents
//  in_*         in   command item  tdata: char_code[7:0], cell_index[18:8]; tuser: mode[1:0]
//  out_*        out  result item   tdata: cell_data[15:0], cursor_pos[26:16]
//  cfg_*        in   apb regs      text_attribute at byte address 0
//
//  a put that scrolls does one copy or fill per cycle through the single
//  write port of the screen memory.
//  after reset the memory is swept to zero with in_tready low; register
//  writes are taken during the sweep.
//  one item is worked on at a time; the next is taken while a result waits,
//  and a stalled result holds the following one in its final state.
module text_console_character_writer_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in transaction
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [tcw_pkg::IN_TDATA_W-1:0]     in_tdata,   // char_code, cell_index
  input  logic [tcw_pkg::MODE_W-1:0]         in_tuser,   // mode
  // out transaction
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tcw_pkg::OUT_TDATA_W-1:0]    out_tdata,  // cell_data, cursor_pos
  // configuration
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [tcw_pkg::CFG_AW-1:0]         cfg_paddr,
  input  logic [tcw_pkg::CFG_DW-1:0]         cfg_pwdata,
  output logic [tcw_pkg::CFG_DW-1:0]         cfg_prdata,
  output logic                               cfg_pready
);

  tcw_pkg::tcw_cmd_t          cmd;
  tcw_pkg::tcw_sts_t          sts;
  logic [tcw_pkg::ATTR_W-1:0] attr;

  // register file
  tcw_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .attr    (attr)
  );

  // controller
  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  tcw_dpath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .attr       (attr),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### rtl/core/tcw_regs.sv
// apb register file holding the text attribute
module tcw_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tcw_pkg::CFG_AW-1:0]    paddr,
  input  logic [tcw_pkg::CFG_DW-1:0]    pwdata,
  output logic [tcw_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready,
  output logic [tcw_pkg::ATTR_W-1:0]    attr
);

  logic [tcw_pkg::ATTR_W-1:0] attr_r;
  logic [tcw_pkg::ATTR_W-1:0] attr_nxt;
  logic                       hit_attr;

  // word decode
  assign hit_attr = (paddr[tcw_pkg::CFG_AW-1] == tcw_pkg::REG_ATTR);

  // write on the access phase
  always_comb begin
    attr_nxt = attr_r;
    if (psel && penable && pwrite && hit_attr) begin
      attr_nxt = pwdata[tcw_pkg::ATTR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tcw_pkg::ATTR_RESET;
    end else begin
      attr_r <= attr_nxt;
    end
  end

  // read back
  assign prdata = hit_attr ? tcw_pkg::CFG_DW'(attr_r) : '0;
  assign pready = 1'b1;
  assign attr   = attr_r;

endmodule

### rtl/core/tcw_ctrl.sv
// sequencing state machine of the text console writer
module tcw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  tcw_pkg::tcw_sts_t sts,
  output tcw_pkg::tcw_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_INIT   = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_PUT    = 9'b000000100,
    S_CLEAR  = 9'b000001000,
    S_POS    = 9'b000010000,
    S_SCROLL = 9'b000100000,
    S_DRAIN  = 9'b001000000,
    S_BOTTOM = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.fill_en = 1'b1;
        if (sts.swp_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          case (sts.in_mode)
            tcw_pkg::MODE_PUT:   state_nxt = S_PUT;
            tcw_pkg::MODE_CLEAR: state_nxt = S_CLEAR;
            default:             state_nxt = S_POS;
          endcase
        end
      end
      S_PUT: begin
        cmd.put_en = 1'b1;
        state_nxt  = S_POS;
      end
      S_CLEAR: begin
        cmd.fill_en    = 1'b1;
        cmd.fill_blank = 1'b1;
        if (sts.swp_end) begin
          cmd.home_en = 1'b1;
          state_nxt   = S_POS;
        end
      end
      S_POS: begin
        cmd.pos_en = 1'b1;
        state_nxt  = sts.scroll ? S_SCROLL : S_DONE;
      end
      S_SCROLL: begin
        cmd.copy_en = 1'b1;
        if (sts.copy_last) begin
          state_nxt = S_DRAIN;
        end
      end
      // last copy write lands here
      S_DRAIN: begin
        state_nxt = S_BOTTOM;
      end
      S_BOTTOM: begin
        cmd.fill_en    = 1'b1;
        cmd.fill_blank = 1'b1;
        if (sts.swp_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/tcw_dpath.sv
// screen memory, cursor and result register of the text console writer
module tcw_dpath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [tcw_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [tcw_pkg::MODE_W-1:0]         in_tuser,
  input  logic [tcw_pkg::ATTR_W-1:0]         attr,
  input  tcw_pkg::tcw_cmd_t                  cmd,
  output tcw_pkg::tcw_sts_t                  sts,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tcw_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int CELLS    = ROWS * COLUMNS;
  localparam int AW       = $clog2(CELLS);
  localparam int CW       = $clog2(COLUMNS);
  localparam int RW       = $clog2(ROWS);
  localparam int CXW      = $clog2(COLUMNS + 8);
  localparam int RXW      = $clog2(ROWS + 1);
  localparam int XW       = ((AW > tcw_pkg::IDX_W) ? AW : tcw_pkg::IDX_W) + 1;
  localparam int PW       = (AW > tcw_pkg::POS_W) ? AW : tcw_pkg::POS_W;
  localparam int COPY_END = (ROWS - 1) * COLUMNS;
  localparam logic [AW-1:0] COLS_A      = AW'(COLUMNS);
  localparam logic [AW-1:0] COPY_LAST_A = AW'(COPY_END - 1);
  localparam logic [AW-1:0] CELL_LAST_A = AW'(CELLS - 1);

  // screen memory
  logic [tcw_pkg::CELL_W-1:0] mem [CELLS];
  logic [tcw_pkg::CELL_W-1:0] rd_data_r;
  logic [AW-1:0]              rd_addr;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [tcw_pkg::CELL_W-1:0] wr_data;

  // item registers
  logic [tcw_pkg::MODE_W-1:0] mode_r;
  logic [tcw_pkg::CHAR_W-1:0] char_r;
  logic [tcw_pkg::IDX_W-1:0]  idx_r;

  // cursor and sweep state
  logic [CW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [AW-1:0]  cur_addr_r, cur_addr_nxt;
  logic [AW-1:0]  swp_r, swp_nxt;
  logic           scroll_r, scroll_nxt;
  logic           cp_wr_vld_r;
  logic [AW-1:0]  cp_wr_addr_r;

  // result register
  logic                       out_valid_r, out_valid_nxt;
  logic [tcw_pkg::CELL_W-1:0] out_cell_r;
  logic [tcw_pkg::POS_W-1:0]  out_pos_r;

  // put-character arithmetic
  logic [CXW-1:0] c_x, c_n;
  logic [RXW-1:0] r_x;
  logic           row_inc;
  logic           char_wr;
  logic           printable;
  logic [RW-1:0]  row_put;
  logic           scroll_put;

  logic [XW-1:0]  idx_x;
  logic           idx_ok;
  logic [PW-1:0]  pos_x;
  logic [tcw_pkg::CELL_W-1:0] blank;

  assign blank     = {attr, tcw_pkg::CH_SPACE};
  assign printable = (char_r >= tcw_pkg::CH_SPACE) && (char_r <= tcw_pkg::CH_DEL);
  assign idx_x     = XW'(idx_r);
  assign idx_ok    = idx_x < XW'(CELLS);
  assign pos_x     = PW'(cur_addr_r);

  // cursor move for one character
  always_comb begin
    c_x     = CXW'(col_r);
    c_n     = c_x;
    row_inc = 1'b0;
    char_wr = 1'b0;
    case (char_r)
      tcw_pkg::CH_BS: begin
        if (c_x != '0) begin
          c_n = c_x - CXW'(1);
        end
      end
      tcw_pkg::CH_TAB: begin
        c_n = (c_x + CXW'(tcw_pkg::TAB_STEP)) & ~CXW'(tcw_pkg::TAB_STEP - 1);
      end
      tcw_pkg::CH_CR: begin
        c_n = '0;
      end
      tcw_pkg::CH_LF: begin
        c_n     = '0;
        row_inc = 1'b1;
      end
      default: begin
        if (printable) begin
          char_wr = 1'b1;
          c_n     = c_x + CXW'(1);
        end
      end
    endcase
    // wrap at the right edge
    if (c_n >= CXW'(COLUMNS)) begin
      c_n     = '0;
      row_inc = 1'b1;
    end
    // scroll past the last row
    r_x = RXW'(row_r) + RXW'(row_inc);
    if (r_x == RXW'(ROWS)) begin
      row_put    = RW'(ROWS - 1);
      scroll_put = 1'b1;
    end else begin
      row_put    = r_x[RW-1:0];
      scroll_put = 1'b0;
    end
  end

  // cursor, sweep and flag updates
  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    cur_addr_nxt = cur_addr_r;
    swp_nxt      = swp_r;
    scroll_nxt   = scroll_r;
    if (cmd.load_item) begin
      swp_nxt    = '0;
      scroll_nxt = 1'b0;
    end
    if (cmd.fill_en || cmd.copy_en) begin
      swp_nxt = swp_r + AW'(1);
    end
    if (cmd.put_en) begin
      col_nxt    = c_n[CW-1:0];
      row_nxt    = row_put;
      scroll_nxt = scroll_put;
    end
    if (cmd.home_en) begin
      col_nxt = '0;
      row_nxt = '0;
    end
    if (cmd.pos_en) begin
      cur_addr_nxt = AW'(row_r) * COLS_A + AW'(col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      cur_addr_r  <= '0;
      swp_r       <= '0;
      scroll_r    <= 1'b0;
      cp_wr_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      cur_addr_r  <= cur_addr_nxt;
      swp_r       <= swp_nxt;
      scroll_r    <= scroll_nxt;
      cp_wr_vld_r <= cmd.copy_en;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      mode_r <= in_tuser;
      char_r <= in_tdata[tcw_pkg::CHAR_W-1:0];
      idx_r  <= in_tdata[tcw_pkg::CHAR_W +: tcw_pkg::IDX_W];
    end
    cp_wr_addr_r <= swp_r;
  end

  // memory port selection, pending copy write first
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = swp_r;
    wr_data = rd_data_r;
    if (cp_wr_vld_r) begin
      wr_en   = 1'b1;
      wr_addr = cp_wr_addr_r;
    end else if (cmd.fill_en) begin
      wr_en   = 1'b1;
      wr_data = cmd.fill_blank ? blank : '0;
    end else if (cmd.put_en && char_wr) begin
      wr_en   = 1'b1;
      wr_addr = cur_addr_r;
      wr_data = {attr, char_r};
    end
  end

  assign rd_addr = cmd.copy_en ? (swp_r + COLS_A) : idx_x[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // result register
  assign out_valid_nxt = cmd.out_load | (out_valid_r & ~out_tready);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cell_r <= ((mode_r == tcw_pkg::MODE_READ) && idx_ok) ? rd_data_r : '0;
      out_pos_r  <= pos_x[tcw_pkg::POS_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{tcw_pkg::OUT_PAD_W{1'b0}}, out_pos_r, out_cell_r};

  // status to the controller
  assign sts.in_mode   = in_tuser;
  assign sts.scroll    = scroll_r;
  assign sts.copy_last = (swp_r == COPY_LAST_A);
  assign sts.swp_end   = (swp_r == CELL_LAST_A);
  assign sts.out_free  = ~out_valid_r | out_tready;

endmodule

### rtl/core/tcw_checker.sv
// port-level checker of the text console writer and its bind
`include "text_console_character_writer_top_assert.svh"

module tcw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [tcw_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int CELLS = ROWS * COLUMNS;

  logic       in_acc, out_acc;
  logic [1:0] cnt_r, cnt_nxt;
  logic       out_stall;
  logic       pos_ok;
  logic [tcw_pkg::OUT_TDATA_W:0] out_view;

  assign in_acc  = in_tvalid & in_tready;
  assign out_acc = out_tvalid & out_tready;

  // result side view for the hold check
  assign out_stall = out_tvalid & ~out_tready;
  assign out_view  = {out_tvalid, out_tdata};
  assign pos_ok    = (out_tdata[26:16] < CELLS) && (out_tdata[31:27] == 5'd0);

  // items taken but not yet delivered
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && !out_acc) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!in_acc && out_acc) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // a stalled result holds
  `TCW_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, $stable(out_view), "stalled result changed")

  // no result without an item behind it
  `TCW_ASSERT_NOW(a_no_extra, clk, rst_n, cnt_r == 2'd0, !out_tvalid, "unexpected result")

  // one item in work plus one waiting result at most
  `TCW_ASSERT_NOW(a_depth, clk, rst_n, cnt_r == 2'd2, !in_tready, "input taken while full")

  // cursor stays on the screen
  `TCW_ASSERT_NOW(a_pos_range, clk, rst_n, out_tvalid, pos_ok, "cursor position off screen")

endmodule

bind text_console_character_writer_top tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (.*);
